FILE: design/assert_macros.svh
// Assertion macros shared by the frame builder RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/dldfb_pkg.sv
// Package for the decimal LED display frame builder: types, codes and tables.
// No dependencies; used by every module of the block.
`default_nettype none

package dldfb_pkg;

    localparam int FRAME_LEN  = 13;
    localparam int NUM_DIGITS = 4;

    // Command codes.
    localparam logic [1:0] CMD_SHOW   = 2'd0;
    localparam logic [1:0] CMD_BRIGHT = 2'd1;
    localparam logic [1:0] CMD_INIT   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Frame element kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Controller command bytes.
    localparam logic [7:0] BYTE_AUTO_INC   = 8'h40;
    localparam logic [7:0] BYTE_ADDR_BASE  = 8'hC0;
    localparam logic [7:0] BYTE_DISPLAY_ON = 8'h88;
    localparam logic [7:0] DOT_BIT         = 8'h80;
    localparam logic [2:0] LEVEL_MAX       = 3'd7;

    // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT, exact for every 16-bit x.
    localparam logic [16:0] RECIP_TEN   = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    // Item travelling through the digit cells.
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] x;       // quotient still to be split
        logic [15:0] digits;  // thousands digit in [15:12], units digit in [3:0]
        logic        dot;
        logic [3:0]  level;
    } conv_t;

    // One frame element held by an element cell.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } elem_t;

    typedef elem_t [FRAME_LEN-1:0] frame_t;

    function automatic logic [7:0] seg_code(logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic elem_t mk_elem(logic [1:0] kind, logic [7:0] data, logic last);
        elem_t e;
        e.valid = 1'b1;
        e.kind  = kind;
        e.data  = (kind == KIND_DATA) ? data : 8'h00;
        e.last  = last;
        return e;
    endfunction

    // Builds the whole element sequence for one converted command.
    function automatic frame_t build_frame(conv_t item);
        frame_t     f;
        logic [3:0] d3, d2, d1, d0;
        logic [7:0] seg3, seg2, seg1, seg0;
        logic [2:0] lv;
        logic       show_last;
        f    = '0;
        d3   = item.digits[15:12];
        d2   = item.digits[11:8];
        d1   = item.digits[7:4];
        d0   = item.digits[3:0];
        // Leading zeros are blanked; the units digit is always shown, but an initialise command blanks all four.
        seg3 = (d3 == 4'd0) ? 8'h00 : seg_code(d3);
        seg2 = (d3 == 4'd0 && d2 == 4'd0) ? 8'h00 : seg_code(d2);
        seg1 = (d3 == 4'd0 && d2 == 4'd0 && d1 == 4'd0) ? 8'h00 : seg_code(d1);
        seg0 = seg_code(d0);
        if (item.dot)
        begin
            seg1 = seg1 | DOT_BIT;
        end
        lv = (item.level > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : item.level[2:0];
        if (item.command == CMD_INIT)
        begin
            seg3 = 8'h00;
            seg2 = 8'h00;
            seg1 = 8'h00;
            seg0 = 8'h00;
        end
        show_last = (item.command == CMD_SHOW);
        case (item.command)
            CMD_SHOW, CMD_INIT:
            begin
                f[0] = mk_elem(KIND_START, 8'h00, 1'b0);
                f[1] = mk_elem(KIND_DATA, BYTE_AUTO_INC, 1'b0);
                f[2] = mk_elem(KIND_STOP, 8'h00, 1'b0);
                f[3] = mk_elem(KIND_START, 8'h00, 1'b0);
                f[4] = mk_elem(KIND_DATA, BYTE_ADDR_BASE, 1'b0);
                f[5] = mk_elem(KIND_DATA, seg3, 1'b0);
                f[6] = mk_elem(KIND_DATA, seg2, 1'b0);
                f[7] = mk_elem(KIND_DATA, seg1, 1'b0);
                f[8] = mk_elem(KIND_DATA, seg0, 1'b0);
                f[9] = mk_elem(KIND_STOP, 8'h00, show_last);
                if (!show_last)
                begin
                    f[10] = mk_elem(KIND_START, 8'h00, 1'b0);
                    f[11] = mk_elem(KIND_DATA, BYTE_DISPLAY_ON | {5'd0, LEVEL_MAX}, 1'b0);
                    f[12] = mk_elem(KIND_STOP, 8'h00, 1'b1);
                end
            end
            CMD_BRIGHT:
            begin
                f[0] = mk_elem(KIND_START, 8'h00, 1'b0);
                f[1] = mk_elem(KIND_DATA, BYTE_DISPLAY_ON | {5'd0, lv}, 1'b0);
                f[2] = mk_elem(KIND_STOP, 8'h00, 1'b1);
            end
            default:
            begin
                f = '0;
            end
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: design/dldfb_digit_cell.sv
// One cell of the binary-to-decimal chain: splits off the lowest decimal digit.
// Depends on dldfb_pkg.
`default_nettype none

module dldfb_digit_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_valid,
    input  dldfb_pkg::conv_t    in_item,
    output logic                out_valid,
    output dldfb_pkg::conv_t    out_item
);
    import dldfb_pkg::*;

    logic        valid_reg;
    conv_t       item_reg;
    conv_t       item_next;
    logic [32:0] prod;
    logic [15:0] quot;
    logic [15:0] quot_x10;
    logic [15:0] rem;

    // Division by ten through the reciprocal; the remainder is then below ten.
    assign prod     = {17'd0, in_item.x} * {16'd0, RECIP_TEN};
    assign quot     = {3'd0, prod[RECIP_SHIFT+12:RECIP_SHIFT]};
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = in_item.x - quot_x10;

    always_comb
    begin
        item_next        = in_item;
        item_next.x      = quot;
        item_next.digits = {rem[3:0], in_item.digits[15:4]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: design/dldfb_elem_cell.sv
// One cell of the output element chain: holds one frame element and passes it on.
// Depends on dldfb_pkg.
`default_nettype none

module dldfb_elem_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 shift,
    input  wire                 load,
    input  dldfb_pkg::elem_t    load_elem,
    input  dldfb_pkg::elem_t    next_elem,
    output dldfb_pkg::elem_t    elem
);
    import dldfb_pkg::*;

    elem_t elem_reg;
    elem_t elem_next;

    always_comb
    begin
        if (load)
        begin
            elem_next = load_elem;
        end
        else if (shift)
        begin
            elem_next = next_elem;
        end
        else
        begin
            elem_next = elem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg <= '0;
        end
        else
        begin
            elem_reg <= elem_next;
        end
    end

    assign elem = elem_reg;

endmodule

`default_nettype wire

FILE: design/decimal_led_display_frame_builder_top.sv
// Usage of the decimal LED display frame builder.
// Input channel (in_valid/in_ready): one command with value, dot and level per
// transfer. Output channel (out_valid/out_ready): one frame element per transfer,
// given as frame_kind and byte_value, with last set on the final element of a
// command. A show command yields 10 elements, brightness 3, initialise 13;
// command code 3 is taken and yields nothing.
// The first element of a command is offered once its input has passed the
// four digit cells, which split the value into decimal digits, one digit per
// cell, and has then been loaded into the element chain.
// The element chain moves one element per cycle toward the output while out_ready
// is high, and the chain is reloaded in the same cycle its final element leaves;
// the digit cells keep converting the next commands meanwhile until a converted
// command waits in the last digit cell.
// When out_ready is low the chain and then the digit cells hold, and in_ready
// drops once a converted command waits for the chain.
// Reset empties both chains; nothing is offered until a command arrives.
`default_nettype none
`include "assert_macros.svh"

module decimal_led_display_frame_builder_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  command,
    input  wire  [15:0] value,
    input  wire         dot,
    input  wire  [3:0]  level,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  frame_kind,
    output logic [7:0]  byte_value,
    output logic        last
);
    import dldfb_pkg::*;

    conv_t                  conv_in;
    conv_t                  conv_q [NUM_DIGITS];
    logic [NUM_DIGITS-1:0]  conv_valid;
    logic                   conv_en;

    frame_t                 chain_q;
    frame_t                 chain_nb;
    frame_t                 frame;
    logic [FRAME_LEN-1:0]   chain_v;
    logic                   shift;
    logic                   tail_empty;
    logic                   load;

    assign conv_in = '{command: command, x: value, digits: 16'd0, dot: dot, level: level};

    assign conv_en  = !conv_valid[NUM_DIGITS-1] || load;
    assign in_ready = conv_en;

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_digit
            if (g == 0)
            begin : g_first
                dldfb_digit_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (conv_en),
                    .in_valid  (in_valid && (command != CMD_NONE)),
                    .in_item   (conv_in),
                    .out_valid (conv_valid[g]),
                    .out_item  (conv_q[g])
                );
            end
            else
            begin : g_rest
                dldfb_digit_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (conv_en),
                    .in_valid  (conv_valid[g-1]),
                    .in_item   (conv_q[g-1]),
                    .out_valid (conv_valid[g]),
                    .out_item  (conv_q[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            chain_v[i] = chain_q[i].valid;
        end
    end

    assign shift      = !chain_v[0] || out_ready;
    assign tail_empty = !(|chain_v[FRAME_LEN-1:1]);
    assign load       = conv_valid[NUM_DIGITS-1] && shift && tail_empty;
    assign frame      = build_frame(conv_q[NUM_DIGITS-1]);
    assign chain_nb   = {elem_t'(0), chain_q[FRAME_LEN-1:1]};

    generate
        for (g = 0; g < FRAME_LEN; g++)
        begin : g_elem
            dldfb_elem_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .load      (load),
                .load_elem (frame[g]),
                .next_elem (chain_nb[g]),
                .elem      (chain_q[g])
            );
        end
    endgenerate

    assign out_valid  = chain_q[0].valid;
    assign frame_kind = chain_q[0].kind;
    assign byte_value = chain_q[0].data;
    assign last       = chain_q[0].last;

    // Valid elements always sit in one unbroken run starting at the head.
    `ASSERT_CLK(a_chain_packed, (chain_v & (chain_v + FRAME_LEN'(1))) == FRAME_LEN'(0), "element chain has a gap")
    `ASSERT_NEVER(a_kind_code, out_valid && frame_kind != KIND_START && frame_kind != KIND_DATA && frame_kind != KIND_STOP, "bad frame kind")
    `ASSERT_NEVER(a_ctrl_zero, out_valid && frame_kind != KIND_DATA && byte_value != 8'h00, "start or stop with nonzero byte")
    `ASSERT_CLK(a_digits_dec, conv_valid[NUM_DIGITS-1] |-> (conv_q[NUM_DIGITS-1].digits[15:12] <= 4'd9 && conv_q[NUM_DIGITS-1].digits[11:8] <= 4'd9 && conv_q[NUM_DIGITS-1].digits[7:4] <= 4'd9 && conv_q[NUM_DIGITS-1].digits[3:0] <= 4'd9), "digit out of range")
    `ASSERT_CLK(a_load_after_last, load && chain_v[0] |-> chain_q[0].last, "chain reloaded before the final element")

endmodule

`default_nettype wire
